### design/bilinear_subdivision_weights_defines.svh
// Assertion macros used by the queue design file.
`ifndef BILINEAR_SUBDIVISION_WEIGHTS_DEFINES_SVH
`define BILINEAR_SUBDIVISION_WEIGHTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bsw_pkg.sv
package bsw_pkg;

    localparam int DIV_W      = 4;
    localparam int COORD_W    = 17;
    localparam int WEIGHT_W   = 18;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [COORD_W-1:0] COORD_ONE   = 17'h10000;
    localparam logic [DIV_W-1:0]   DIV_RESET   = 4'd1;
    localparam logic [DIV_W-1:0]   DIV_MIN     = 4'd1;
    localparam logic               REG_DIVISIONS = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } bsw_q_status_t;

endpackage

### design/bsw_front.sv
module bsw_front
    import bsw_pkg::*;
#(
    parameter int MAX_DIVISIONS = 8
)
(
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [COORD_W-1:0]         px,
    input  logic [COORD_W-1:0]         py,
    input  logic [DIV_W-1:0]           n_eff,
    input  bsw_q_status_t              q_status,
    output logic                       push,
    output logic [MAX_DIVISIONS:0]     ax,
    output logic [MAX_DIVISIONS:0]     ay,
    output logic [DIV_W-1:0]           n_out
);

    localparam int CW = MAX_DIVISIONS + 1;
    localparam int SW = COORD_W + MAX_DIVISIONS + 1;

    function automatic logic [CW-1:0] centre(input logic [COORD_W-1:0] coord,
                                             input logic [DIV_W-1:0] n);
        logic [COORD_W-1:0]    c;
        logic [SW-1:0]         s;
        logic [SW-17:0]        k;
        logic [SW-17:0]        km1;
        c = (coord > COORD_ONE) ? COORD_ONE : coord;
        s = (SW'(c) << n) + SW'(17'h0FFFF);
        k = s[SW-1:16];
        km1 = (k != '0) ? (k - (SW-16)'(1)) : k;
        return {km1[MAX_DIVISIONS-1:0], 1'b1};
    endfunction

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;
    assign ax       = centre(px, n_eff);
    assign ay       = centre(py, n_eff);
    assign n_out    = n_eff;

endmodule

### design/bsw_queue.sv
`include "bilinear_subdivision_weights_defines.svh"

module bsw_queue
    import bsw_pkg::*;
#(
    parameter int WIDTH = 22,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output bsw_q_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    `BSW_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !status.full, "Push into a full queue.")
    `BSW_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !status.empty, "Pop from an empty queue.")
    `BSW_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "Count did not rise.")
    `BSW_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CNT_W'(1), "Count did not fall.")

endmodule

### design/bsw_back.sv
module bsw_back
    import bsw_pkg::*;
#(
    parameter int MAX_DIVISIONS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bsw_q_status_t           q_status,
    input  logic [MAX_DIVISIONS:0]  ax,
    input  logic [MAX_DIVISIONS:0]  ay,
    input  logic [DIV_W-1:0]        n,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [WEIGHT_W-1:0]     w_top_left,
    output logic [WEIGHT_W-1:0]     w_top_right,
    output logic [WEIGHT_W-1:0]     w_bottom_left,
    output logic [WEIGHT_W-1:0]     w_bottom_right
);

    localparam int CW  = MAX_DIVISIONS + 1;
    localparam int PW  = 2 * CW;
    localparam int FBW = $clog2(2 * MAX_DIVISIONS + 3);
    localparam int XW  = PW + WEIGHT_W;

    logic          a_valid_reg, a_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          adv_a, adv_b;
    logic [CW:0]   full;
    logic [CW-1:0] bx, by;
    logic [PW-1:0] p_tl_reg, p_tr_reg, p_bl_reg, p_br_reg;
    logic [FBW-1:0] fbits_reg;
    logic [WEIGHT_W-1:0] w_tl_reg, w_tr_reg, w_bl_reg, w_br_reg;

    function automatic logic [WEIGHT_W-1:0] to_q18(input logic [PW-1:0] prod,
                                                   input logic [FBW-1:0] fbits);
        logic [XW-1:0] x;
        x = {prod, {WEIGHT_W{1'b0}}} >> fbits;
        return x[WEIGHT_W-1:0];
    endfunction

    assign adv_b = !out_valid_reg || !out_stall;
    assign adv_a = !a_valid_reg || adv_b;
    assign pop   = !q_status.empty && adv_a;

    assign full = (CW + 1)'(1) << ((DIV_W + 1)'(n) + (DIV_W + 1)'(1));
    assign bx   = CW'(full - (CW + 1)'(ax));
    assign by   = CW'(full - (CW + 1)'(ay));

    always_comb
    begin
        a_valid_next   = adv_a ? pop : a_valid_reg;
        out_valid_next = adv_b ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_tl_reg  <= PW'(bx) * PW'(ay);
            p_tr_reg  <= PW'(ax) * PW'(ay);
            p_bl_reg  <= PW'(bx) * PW'(by);
            p_br_reg  <= PW'(ax) * PW'(by);
            fbits_reg <= FBW'({n, 1'b0}) + FBW'(2);
        end
        if (adv_b && a_valid_reg)
        begin
            w_tl_reg <= to_q18(p_tl_reg, fbits_reg);
            w_tr_reg <= to_q18(p_tr_reg, fbits_reg);
            w_bl_reg <= to_q18(p_bl_reg, fbits_reg);
            w_br_reg <= to_q18(p_br_reg, fbits_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign w_top_left     = w_tl_reg;
    assign w_top_right    = w_tr_reg;
    assign w_bottom_left  = w_bl_reg;
    assign w_bottom_right = w_br_reg;

endmodule

### design/bilinear_subdivision_weights.sv
// Bilinear subdivision weights: each transfer of a point (px, py) in Q1.16 gives one transfer
// of four Q0.18 corner weights, evaluated at the centre of the sub-cell that holds the point
// after "divisions" halvings (register at address 0, reset value 1, zero acts as one, values
// above MAX_DIVISIONS saturate). A new point is taken every cycle while in_stall is low. The
// front computes the cell centres as the point enters a four-entry queue; the back pops it
// into a register of four products and then scales them into the output register. in_stall
// rises only when the queue is full.
module bilinear_subdivision_weights
    import bsw_pkg::*;
#(
    parameter int MAX_DIVISIONS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_W-1:0]    px,
    input  logic [COORD_W-1:0]    py,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WEIGHT_W-1:0]   w_top_left,
    output logic [WEIGHT_W-1:0]   w_top_right,
    output logic [WEIGHT_W-1:0]   w_bottom_left,
    output logic [WEIGHT_W-1:0]   w_bottom_right
);

    localparam int CW  = MAX_DIVISIONS + 1;
    localparam int QW  = 2 * CW + DIV_W;
    localparam int QDEPTH = 4;

    logic [DIV_W-1:0] divisions_reg, divisions_next;
    logic [DIV_W-1:0] n_eff;
    logic             push, pop;
    bsw_q_status_t    q_status;
    logic [CW-1:0]    f_ax, f_ay, b_ax, b_ay;
    logic [DIV_W-1:0] f_n, b_n;
    logic [QW-1:0]    q_rdata;

    always_comb
    begin
        divisions_next = divisions_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_DIVISIONS))
        begin
            divisions_next = pwdata[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= DIV_RESET;
        end
        else
        begin
            divisions_reg <= divisions_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIVISIONS) ? APB_DATA_W'(divisions_reg) : '0;

    always_comb
    begin
        if (divisions_reg < DIV_MIN)
        begin
            n_eff = DIV_MIN;
        end
        else if (divisions_reg > DIV_W'(MAX_DIVISIONS))
        begin
            n_eff = DIV_W'(MAX_DIVISIONS);
        end
        else
        begin
            n_eff = divisions_reg;
        end
    end

    bsw_front #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .px       (px),
        .py       (py),
        .n_eff    (n_eff),
        .q_status (q_status),
        .push     (push),
        .ax       (f_ax),
        .ay       (f_ay),
        .n_out    (f_n)
    );

    bsw_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({f_ax, f_ay, f_n}),
        .pop    (pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    assign b_ax = q_rdata[QW-1 -: CW];
    assign b_ay = q_rdata[DIV_W + CW - 1 -: CW];
    assign b_n  = q_rdata[DIV_W-1:0];

    bsw_back #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .ax             (b_ax),
        .ay             (b_ay),
        .n              (b_n),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .w_top_left     (w_top_left),
        .w_top_right    (w_top_right),
        .w_bottom_left  (w_bottom_left),
        .w_bottom_right (w_bottom_right)
    );

endmodule

### dv/bilinear_subdivision_weights_test.sv
`timescale 1ns / 1ps

module bilinear_subdivision_weights_test
    import bsw_pkg::*;
();

    localparam int MAX_DIVS         = 8;
    localparam int RESET_CYCLES     = 9;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 4;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_POINTS     = 60;

    localparam logic [APB_ADDR_W-1:0] ADDR_DIVISIONS = APB_ADDR_W'(4 * REG_DIVISIONS);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = APB_ADDR_W'(4);

    typedef struct packed {
        logic [WEIGHT_W-1:0] top_left;
        logic [WEIGHT_W-1:0] top_right;
        logic [WEIGHT_W-1:0] bottom_left;
        logic [WEIGHT_W-1:0] bottom_right;
    } corner_weights_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_W-1:0]    px = '0;
    logic [COORD_W-1:0]    py = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [WEIGHT_W-1:0]   w_top_left;
    logic [WEIGHT_W-1:0]   w_top_right;
    logic [WEIGHT_W-1:0]   w_bottom_left;
    logic [WEIGHT_W-1:0]   w_bottom_right;

    logic [DIV_W-1:0]      divisions_shadow = DIV_RESET;
    corner_weights_t       weights_due[$];
    int                    fail_count = 0;
    bit                    gaps_on = 1'b1;
    bit                    stall_on = 1'b1;
    bit                    long_hold_req = 1'b0;

    bilinear_subdivision_weights #(
        .MAX_DIVISIONS(MAX_DIVS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .px(px),
        .py(py),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .w_top_left(w_top_left),
        .w_top_right(w_top_right),
        .w_bottom_left(w_bottom_left),
        .w_bottom_right(w_bottom_right)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned effective_divisions(input logic [DIV_W-1:0] div);
        int unsigned n;
        n = div;
        if (n < 1) n = 1;
        if (n > MAX_DIVS) n = MAX_DIVS;
        return n;
    endfunction

    // Twice the cell index plus one: the cell center over 2^(n+1).
    function automatic longint unsigned centre_numerator(input logic [COORD_W-1:0] coord,
                                                         input int unsigned n);
        longint unsigned c;
        longint unsigned k;
        c = coord;
        if (c > COORD_ONE) c = COORD_ONE;
        k = ((c << n) + COORD_ONE - 1) >> 16;
        if (k > 0) k = k - 1;
        return 2 * k + 1;
    endfunction

    function automatic logic [WEIGHT_W-1:0] scale_weight(input longint unsigned prod,
                                                         input int unsigned fbits);
        if (fbits <= WEIGHT_W) return WEIGHT_W'(prod << (WEIGHT_W - fbits));
        return WEIGHT_W'(prod >> (fbits - WEIGHT_W));
    endfunction

    function automatic corner_weights_t subcell_weights(input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y,
                                                        input logic [DIV_W-1:0] div);
        int unsigned     n;
        int unsigned     fbits;
        longint unsigned full;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned bx;
        longint unsigned by;
        corner_weights_t w;
        n = effective_divisions(div);
        full = 64'd1 << (n + 1);
        ax = centre_numerator(x, n);
        ay = centre_numerator(y, n);
        bx = full - ax;
        by = full - ay;
        fbits = 2 * (n + 1);
        w.top_left     = scale_weight(bx * ay, fbits);
        w.top_right    = scale_weight(ax * ay, fbits);
        w.bottom_left  = scale_weight(bx * by, fbits);
        w.bottom_right = scale_weight(ax * by, fbits);
        return w;
    endfunction

    // Mostly points inside the square, some near cell boundaries, some above one.
    function automatic logic [COORD_W-1:0] random_coord(input int unsigned n);
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 9);
        if (pick < 6) return COORD_W'($urandom_range(0, 65536));
        if (pick < 8)
        begin
            v = int'($urandom_range(0, 1 << n)) << (16 - n);
            v = v + int'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
            return COORD_W'(v);
        end
        return COORD_W'($urandom_range(65537, 131071));
    endfunction

    function automatic void check_weight(input string name, input logic [WEIGHT_W-1:0] want,
                                         input logic [WEIGHT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        corner_weights_t want;
        if (rst_n && in_valid && !in_stall)
            weights_due.push_back(subcell_weights(px, py, divisions_shadow));
        if (rst_n && out_valid && !out_stall)
        begin
            if (weights_due.size() == 0)
            begin
                $error("Weight transfer with no point outstanding");
                fail_count++;
            end
            else
            begin
                want = weights_due.pop_front();
                check_weight("w_top_left", want.top_left, w_top_left);
                check_weight("w_top_right", want.top_right, w_top_right);
                check_weight("w_bottom_left", want.bottom_left, w_bottom_left);
                check_weight("w_bottom_right", want.bottom_right, w_bottom_right);
            end
        end
    end

    initial
    begin : stall_gen
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        do @(posedge clk); while (in_stall);
    endtask

    // The first edge lets the scoreboard record a point taken at the previous edge.
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (weights_due.size() != 0 && waited < DRAIN_LIMIT);
        if (weights_due.size() != 0)
        begin
            $error("%0d weight transfers never arrived", weights_due.size());
            fail_count++;
            weights_due.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_DIVISIONS) divisions_shadow = data[DIV_W-1:0];
    endtask

    task automatic set_divisions(input logic [APB_DATA_W-1:0] value);
        wait_drained();
        apb_write(ADDR_DIVISIONS, value);
    endtask

    task automatic test_reset_value();
        send_point('0, '0);
        send_point(COORD_ONE, COORD_ONE);
        send_point(COORD_W'(32768), COORD_W'(32769));
        send_point(COORD_W'(131071), COORD_W'(65537));
    endtask

    task automatic test_division_extremes();
        logic [APB_DATA_W-1:0] settings[4];
        logic [COORD_W-1:0]    tie;
        settings = '{32'd0, 32'd8, 32'd15, 32'd9};
        foreach (settings[i])
        begin
            set_divisions(settings[i]);
            tie = COORD_W'(1) << (16 - effective_divisions(divisions_shadow));
            send_point('0, COORD_W'(131071));
            send_point(COORD_ONE, '0);
            send_point(tie, tie + 1'b1);
            send_point(tie + 1'b1, tie);
        end
    endtask

    task automatic test_unmapped_register();
        set_divisions(32'd3);
        apb_write(ADDR_UNMAPPED, 32'd7);
        send_point(COORD_W'(8192), COORD_W'(8193));
        send_point(COORD_W'(40000), COORD_W'(65535));
    endtask

    task automatic test_random_points();
        logic [APB_DATA_W-1:0] settings[RANDOM_PHASES];
        int unsigned           n;
        settings = '{32'd1, 32'd8, 32'hFFFF_FFF2, 32'd0, 32'd15, $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom()};
        foreach (settings[i])
        begin
            set_divisions(settings[i]);
            n = effective_divisions(divisions_shadow);
            gaps_on = (i % 3 != 2);
            stall_on = (i % 3 != 2);
            repeat (PHASE_POINTS) send_point(random_coord(n), random_coord(n));
        end
        gaps_on = 1'b1;
        stall_on = 1'b1;
    endtask

    // The receiver holds off long enough for the queue to fill and stall the input.
    task automatic test_output_backpressure();
        int unsigned n;
        n = effective_divisions(divisions_shadow);
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_point(random_coord(n), random_coord(n));
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        int unsigned n;
        n = effective_divisions(divisions_shadow);
        repeat (10) send_point(random_coord(n), random_coord(n));
        wait_drained();
        repeat (10) send_point(random_coord(n), random_coord(n));
    endtask

    task automatic test_steady_stream();
        int unsigned n;
        set_divisions($urandom_range(1, 8));
        n = effective_divisions(divisions_shadow);
        gaps_on = 1'b0;
        stall_on = 1'b0;
        repeat (50) send_point(random_coord(n), random_coord(n));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_value();
        test_division_extremes();
        test_unmapped_register();
        test_random_points();
        test_output_backpressure();
        test_drain_pause();
        test_steady_stream();
        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
